// ===== sv/cas_pkg.sv =====
// Shared constants, register codes and controller/datapath types for the sharpening block.
`default_nettype none

package cas_pkg;

  localparam int unsigned MAX_WIDTH_DEF     = 2048;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned MAX_HEIGHT        = 4096;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned COL_OUT_W  = 11;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned IWIDTH_W   = 12;
  localparam int unsigned IHEIGHT_W  = 13;
  localparam int unsigned SHARP_W    = 9;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [IWIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [IHEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2,
    REG_SHARP  = 2'd3
  } cas_reg_t;

  // operand set loaded into the shared divider
  typedef enum logic [1:0] {
    DIV_PEAK  = 2'd0,
    DIV_RATIO = 2'd1,
    DIV_QUOT  = 2'd2
  } cas_dsel_t;

  // controller -> datapath commands
  typedef struct packed {
    logic      accept;
    logic      capture;
    logic      div_start;
    cas_dsel_t dsel;
    logic      take_peak;
    logic      sqrt_start;
    logic      sqrt_zero;
    logic      mul1;
    logic      mul2;
    logic      res_zero;
    logic      take_q;
    logic      next_ch;
    logic      out_load;
    logic      slot_adv;
  } cas_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic interior;
    logic div_done;
    logic sqrt_done;
    logic mx_zero;
    logic neg;
    logic last_ch;
    logic slot_en;
    logic slot_last;
    logic out_free;
  } cas_sts_t;

  // one 8-bit channel of a packed pixel (red low, blue high)
  function automatic logic [CH_W-1:0] chan_of(input logic [PIX_W-1:0] p, input logic [1:0] k);
    logic [CH_W-1:0] v;
    case (k)
      2'd1:    v = p[15:8];
      2'd2:    v = p[23:16];
      default: v = p[7:0];
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cas_if.sv =====
// Valid/ready stream interfaces for the pixel input and the result output.
`default_nettype none

interface cas_in_if;
  logic                      valid;
  logic                      ready;
  logic [cas_pkg::CH_W-1:0]  red_or_grey;
  logic [cas_pkg::CH_W-1:0]  green_in;
  logic [cas_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, output red_or_grey, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_or_grey, input green_in, input blue_in,
                  output ready);
endinterface

interface cas_out_if;
  logic                          valid;
  logic                          ready;
  logic [cas_pkg::CH_W-1:0]      out_red_or_grey;
  logic [cas_pkg::CH_W-1:0]      out_green;
  logic [cas_pkg::CH_W-1:0]      out_blue;
  logic [cas_pkg::COL_OUT_W-1:0] out_column;
  logic [cas_pkg::ROW_W-1:0]     out_row;
  logic                          last_of_run;
  logic                          frame_done;

  modport source (output valid, output out_red_or_grey, output out_green, output out_blue,
                  output out_column, output out_row, output last_of_run,
                  output frame_done, input ready);
  modport sink   (input valid, input out_red_or_grey, input out_green, input out_blue,
                  input out_column, input out_row, input last_of_run,
                  input frame_done, output ready);
endinterface

`default_nettype wire

// ===== sv/contrast_adaptive_sharpen_3x3.sv =====
// Top level: 3x3 contrast adaptive sharpening over a raster pixel stream.
// Border-only items go straight to result emission. An interior item runs the divider
//   for the peak weight, then per channel (one for grey, three for RGB) an optional
//   ratio division, the square root, two multiplies and an optional quotient division;
//   divider and square root produce one bit per cycle. One item is handled at a time.
// Reset (synchronous, rst_n low): counters, window and handshakes clear; line stores are not.
`default_nettype none

module contrast_adaptive_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH     = cas_pkg::MAX_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = cas_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  cas_in_if.sink                              in_px,
  cas_out_if.source                           out_px,
  input  wire logic                           cfg_we,
  input  wire logic [cas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cas_pkg::*;

  cas_cmd_t cmd;
  cas_sts_t sts;

  cas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .in_ready (in_px.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cas_dp #(
    .MAX_WIDTH     (MAX_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_red_or_grey  (in_px.red_or_grey),
    .in_green_in     (in_px.green_in),
    .in_blue_in      (in_px.blue_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_px.ready),
    .out_valid       (out_px.valid),
    .out_red_or_grey (out_px.out_red_or_grey),
    .out_green       (out_px.out_green),
    .out_blue        (out_px.out_blue),
    .out_column      (out_px.out_column),
    .out_row         (out_px.out_row),
    .last_of_run     (out_px.last_of_run),
    .frame_done      (out_px.frame_done)
  );

endmodule

`default_nettype wire

// ===== sv/cas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cas_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/cas_ctrl.sv =====
// Sequencing state machine: accept, line read, per-channel sharpen steps, result emission.
`default_nettype none

module cas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire cas_pkg::cas_sts_t sts,
  output      cas_pkg::cas_cmd_t cmd
);
  import cas_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD   = 11'b000_0000_0010,
    S_PEAK = 11'b000_0000_0100,
    S_MM   = 11'b000_0000_1000,
    S_RAT  = 11'b000_0001_0000,
    S_SQRT = 11'b000_0010_0000,
    S_MUL1 = 11'b000_0100_0000,
    S_MUL2 = 11'b000_1000_0000,
    S_CHK  = 11'b001_0000_0000,
    S_QDIV = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    cmd       = '0;
    cmd.dsel  = DIV_PEAK;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        cmd.capture = 1'b1;
        if (sts.interior) begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DIV_PEAK;
          state_nxt     = S_PEAK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_PEAK: begin
        if (sts.div_done) begin
          cmd.take_peak = 1'b1;
          state_nxt     = S_MM;
        end
      end
      S_MM: begin
        if (sts.mx_zero) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_zero  = 1'b1;
          state_nxt      = S_SQRT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DIV_RATIO;
          state_nxt     = S_RAT;
        end
      end
      S_RAT: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.neg) begin
          cmd.res_zero = 1'b1;
          if (sts.last_ch) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.next_ch = 1'b1;
            state_nxt   = S_MM;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.dsel      = DIV_QUOT;
          state_nxt     = S_QDIV;
        end
      end
      S_QDIV: begin
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          if (sts.last_ch) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.next_ch = 1'b1;
            state_nxt   = S_MM;
          end
        end
      end
      S_EMIT: begin
        // walk the three result slots, skipping those not produced
        if (!sts.slot_en || sts.out_free) begin
          cmd.out_load = sts.slot_en;
          cmd.slot_adv = 1'b1;
          if (sts.slot_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/cas_dp.sv =====
// Datapath: config registers, counters, line stores, window, divider, square root, output register.
`default_nettype none

module cas_dp #(
  parameter int unsigned MAX_WIDTH     = cas_pkg::MAX_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = cas_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [cas_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [cas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [cas_pkg::CH_W-1:0]      in_red_or_grey,
  input  wire logic [cas_pkg::CH_W-1:0]      in_green_in,
  input  wire logic [cas_pkg::CH_W-1:0]      in_blue_in,
  input  wire cas_pkg::cas_cmd_t             cmd,
  output      cas_pkg::cas_sts_t             sts,
  input  wire logic                          out_ready,
  output      logic                          out_valid,
  output      logic [cas_pkg::CH_W-1:0]      out_red_or_grey,
  output      logic [cas_pkg::CH_W-1:0]      out_green,
  output      logic [cas_pkg::CH_W-1:0]      out_blue,
  output      logic [cas_pkg::COL_OUT_W-1:0] out_column,
  output      logic [cas_pkg::ROW_W-1:0]     out_row,
  output      logic                          last_of_run,
  output      logic                          frame_done
);
  import cas_pkg::*;

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WX = (CW + 1 > IWIDTH_W) ? CW + 1 : IWIDTH_W;
  localparam int unsigned NW = F + 9;
  localparam int unsigned DW = F + 2;
  localparam int unsigned RW = 2 * F + 2;
  localparam int unsigned KW = $clog2(NW + 1);
  localparam int unsigned PW = F + 10;

  // ---------------- configuration registers
  logic [IWIDTH_W-1:0]  width_r;
  logic [IHEIGHT_W-1:0] height_r;
  logic                 mode_r;
  logic [SHARP_W-1:0]   sharp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= 1'b0;
      sharp_r  <= '0;
    end else if (cfg_we) begin
      case (cas_reg_t'(cfg_addr))
        REG_WIDTH:  width_r  <= cfg_wdata[IWIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[IHEIGHT_W-1:0];
        REG_MODE:   mode_r   <= cfg_wdata[0];
        REG_SHARP:  sharp_r  <= cfg_wdata[SHARP_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------- frame bounds (last column / last row index)
  logic [WX-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    if (width_r == '0) begin
      w_m1 = '0;
    end else if (WX'(width_r) > WX'(MAX_WIDTH)) begin
      w_m1 = WX'(MAX_WIDTH - 1);
    end else begin
      w_m1 = WX'(width_r) - WX'(1);
    end
    if (height_r == '0) begin
      h_m1 = '0;
    end else if (height_r > IHEIGHT_W'(MAX_HEIGHT)) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(height_r - IHEIGHT_W'(1));
    end
  end

  // ---------------- position counters and per-item latches
  logic [CW-1:0]    col_cnt_r, c_r;
  logic [ROW_W-1:0] row_cnt_r, r_r;
  logic             end_row, last_row, interior;
  logic             end_row_r, last_row_r, int_r;
  logic [PIX_W-1:0] px_r;

  assign end_row  = WX'(col_cnt_r) >= w_m1;
  assign last_row = row_cnt_r >= h_m1;
  assign interior = (col_cnt_r >= CW'(2)) && (row_cnt_r >= ROW_W'(2)) &&
                    (WX'(col_cnt_r) <= w_m1) && (row_cnt_r <= h_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.accept) begin
      if (end_row) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r       <= {in_blue_in, in_green_in, in_red_or_grey};
      c_r        <= col_cnt_r;
      r_r        <= row_cnt_r;
      end_row_r  <= end_row;
      last_row_r <= last_row;
      int_r      <= interior;
    end
  end

  // ---------------- line stores
  logic [PIX_W-1:0] top_rd, mid_rd;

  cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.capture),
    .waddr (c_r),
    .wdata (mid_rd),
    .re    (cmd.accept),
    .raddr (col_cnt_r),
    .rdata (top_rd)
  );

  cas_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.capture),
    .waddr (c_r),
    .wdata (px_r),
    .re    (cmd.accept),
    .raddr (col_cnt_r),
    .rdata (mid_rd)
  );

  // ---------------- 3x3 window, win_r[column][row], column 0 newest
  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] mid_r, res_r;
  logic [1:0]       ch_r, slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          win_r[x][y] <= '0;
        end
      end
    end else if (cmd.capture) begin
      win_r[2]    <= win_r[1];
      win_r[1]    <= win_r[0];
      win_r[0][0] <= top_rd;
      win_r[0][1] <= mid_rd;
      win_r[0][2] <= px_r;
    end
  end

  // ---------------- neighborhood of the current channel
  logic [CH_W-1:0] nb_a, nb_b, nb_c, nb_d, nb_e, nb_f, nb_g, nb_h, nb_i;
  logic [CH_W-1:0] cmin, cmax, fmin, fmax;
  logic [8:0]      mn, mx, lim, num9;
  logic [9:0]      s10;
  logic [F+7:0]    ne;

  assign nb_a = chan_of(win_r[2][0], ch_r);
  assign nb_b = chan_of(win_r[1][0], ch_r);
  assign nb_c = chan_of(win_r[0][0], ch_r);
  assign nb_d = chan_of(win_r[2][1], ch_r);
  assign nb_e = chan_of(win_r[1][1], ch_r);
  assign nb_f = chan_of(win_r[0][1], ch_r);
  assign nb_g = chan_of(win_r[2][2], ch_r);
  assign nb_h = chan_of(win_r[1][2], ch_r);
  assign nb_i = chan_of(win_r[0][2], ch_r);

  // cross extremes, then widened over the diagonals
  always_comb begin
    logic [CH_W-1:0] cr [4];
    logic [CH_W-1:0] dg [4];
    cr = '{nb_b, nb_d, nb_f, nb_h};
    dg = '{nb_a, nb_c, nb_g, nb_i};
    cmin = nb_e;
    cmax = nb_e;
    for (int k = 0; k < 4; k++) begin
      if (cr[k] < cmin) cmin = cr[k];
      if (cr[k] > cmax) cmax = cr[k];
    end
    fmin = cmin;
    fmax = cmax;
    for (int k = 0; k < 4; k++) begin
      if (dg[k] < fmin) fmin = dg[k];
      if (dg[k] > fmax) fmax = dg[k];
    end
  end

  assign mn   = {1'b0, cmin} + {1'b0, fmin};
  assign mx   = {1'b0, cmax} + {1'b0, fmax};
  assign lim  = 9'd510 - mx;
  assign num9 = (mn < lim) ? mn : lim;
  assign s10  = {2'b00, nb_b} + {2'b00, nb_d} + {2'b00, nb_f} + {2'b00, nb_h};
  assign ne   = {nb_e, {F{1'b0}}};

  // ---------------- weights and products
  logic [F-1:0]    peak_r, wq_r;
  logic [PW-1:0]   p_r;
  logic [2*F:0]    prod1;
  logic [F:0]      den;
  logic [F+7:0]    qnum;
  logic [SHARP_W-1:0] sh_eff;
  logic [10:0]     sh3;
  logic [11:0]     peak_dsr;
  logic [F:0]      root_r;

  assign sh_eff   = (sharp_r > SHARP_W'(256)) ? SHARP_W'(256) : sharp_r;
  assign sh3      = {1'b0, sh_eff, 1'b0} + {2'b00, sh_eff};
  assign peak_dsr = 12'd2048 - {1'b0, sh3};
  assign prod1    = (2*F+1)'(root_r) * (2*F+1)'(peak_r);
  assign den      = {1'b1, {F{1'b0}}} - (F+1)'({wq_r, 2'b00});
  assign qnum     = ne - p_r[F+7:0];

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      wq_r <= prod1[2*F-1:F];
    end
    if (cmd.mul2) begin
      p_r <= PW'(wq_r) * PW'(s10);
    end
  end

  // ---------------- shared restoring divider, one quotient bit a cycle
  logic [NW-1:0] dvd_r, dvd_in;
  logic [DW-1:0] dsr_r, dsr_in, rem_r;
  logic [DW:0]   dtmp;
  logic          dge, div_busy_r;
  logic [KW-1:0] div_cnt_r;

  always_comb begin
    case (cmd.dsel)
      DIV_RATIO: begin
        dvd_in = NW'(num9) << F;
        dsr_in = DW'(mx);
      end
      DIV_QUOT: begin
        dvd_in = NW'(qnum);
        dsr_in = DW'(den);
      end
      default: begin
        dvd_in = NW'(256) << F;
        dsr_in = DW'(peak_dsr);
      end
    endcase
  end

  assign dtmp = {rem_r, dvd_r[NW-1]};
  assign dge  = dtmp >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == KW'(NW - 1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r     <= dvd_in;
      dsr_r     <= dsr_in;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      rem_r     <= dge ? DW'(dtmp - {1'b0, dsr_r}) : dtmp[DW-1:0];
      dvd_r     <= {dvd_r[NW-2:0], dge};
      div_cnt_r <= div_cnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_peak) begin
      peak_r <= dvd_r[F-1:0];
    end
  end

  // ---------------- square root, one root bit a cycle
  logic [RW-1:0] rad_r;
  logic [F+2:0]  srem_r;
  logic [F+4:0]  stmp, strial;
  logic          sge, sq_busy_r;
  logic [KW-1:0] sq_cnt_r;
  logic [F:0]    ratio_c;

  assign ratio_c = (dvd_r > (NW'(1) << F)) ? (F+1)'(1) << F : dvd_r[F:0];
  assign stmp    = {srem_r, rad_r[RW-1:RW-2]};
  assign strial  = {2'b00, root_r, 2'b01};
  assign sge     = stmp >= strial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_cnt_r == KW'(F)) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r    <= cmd.sqrt_zero ? '0 : RW'(ratio_c) << F;
      root_r   <= '0;
      srem_r   <= '0;
      sq_cnt_r <= '0;
    end else if (sq_busy_r) begin
      srem_r   <= sge ? (F+3)'(stmp - strial) : stmp[F+2:0];
      root_r   <= {root_r[F-1:0], sge};
      rad_r    <= rad_r << 2;
      sq_cnt_r <= sq_cnt_r + KW'(1);
    end
  end

  // ---------------- channel results and slot walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_r <= win_r[0][1];
      mid_r <= mid_rd;
    end else if (cmd.res_zero) begin
      res_r[{ch_r, 3'b000} +: CH_W] <= '0;
    end else if (cmd.take_q) begin
      res_r[{ch_r, 3'b000} +: CH_W] <= (dvd_r > NW'(255)) ? 8'hFF : dvd_r[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= '0;
      slot_r <= '0;
    end else if (cmd.capture) begin
      ch_r   <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.next_ch) begin
        ch_r <= ch_r + 2'd1;
      end
      if (cmd.slot_adv) begin
        slot_r <= slot_r + 2'd1;
      end
    end
  end

  // which results this item produces
  logic [2:0] slot_on;
  logic       cur_en, cur_last;
  logic [PIX_W-1:0]    cur_px;
  logic [CW-1:0]       cur_col;
  logic [ROW_W-1:0]    cur_row;

  assign slot_on[0] = (r_r != '0) && (c_r != '0);
  assign slot_on[1] = (r_r != '0) && end_row_r;
  assign slot_on[2] = last_row_r;

  always_comb begin
    case (slot_r)
      2'd0: begin
        cur_en   = slot_on[0];
        cur_last = !(slot_on[1] || slot_on[2]);
        cur_px   = res_r;
        cur_col  = c_r - CW'(1);
        cur_row  = r_r - ROW_W'(1);
      end
      2'd1: begin
        cur_en   = slot_on[1];
        cur_last = !slot_on[2];
        cur_px   = mid_r;
        cur_col  = c_r;
        cur_row  = r_r - ROW_W'(1);
      end
      default: begin
        cur_en   = slot_on[2];
        cur_last = 1'b1;
        cur_px   = px_r;
        cur_col  = c_r;
        cur_row  = r_r;
      end
    endcase
  end

  // ---------------- output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red_or_grey <= cur_px[7:0];
      out_green       <= mode_r ? cur_px[15:8] : '0;
      out_blue        <= mode_r ? cur_px[23:16] : '0;
      out_column      <= COL_OUT_W'(cur_col);
      out_row         <= cur_row;
      last_of_run     <= cur_last;
      frame_done      <= cur_last && end_row_r && last_row_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- status
  assign sts.interior  = int_r;
  assign sts.div_done  = !div_busy_r;
  assign sts.sqrt_done = !sq_busy_r;
  assign sts.mx_zero   = (mx == '0);
  assign sts.neg       = p_r >= PW'(ne);
  assign sts.last_ch   = mode_r ? (ch_r == 2'd2) : (ch_r == 2'd0);
  assign sts.slot_en   = cur_en;
  assign sts.slot_last = (slot_r == 2'd2);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire
